// ===== design/lsps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared types, widths and register codes of the LED strip pulse serializer.
// ----------------------------------------------------------------------------
package lsps_pkg;

  localparam int COLOUR_W           = 24;
  localparam int TICK_W             = 10;
  localparam int CHIP_W             = 8;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 10;

  localparam int LSPS_BITS_PER_CHIP = 24;
  localparam int LSPS_GROUPS        = 4;

  // register reset values
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = TICK_W'(60);
  localparam logic [TICK_W-1:0] RST_ONE_HIGH   = TICK_W'(127);
  localparam logic [TICK_W-1:0] RST_BIT_PERIOD = TICK_W'(186);
  localparam logic [CHIP_W-1:0] RST_GROUP_A    = CHIP_W'(6);
  localparam logic [CHIP_W-1:0] RST_GROUP_BCD  = CHIP_W'(5);

  // beat kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH  = 3'd0,
    CFG_ONE_HIGH   = 3'd1,
    CFG_BIT_PERIOD = 3'd2,
    CFG_GROUP_A    = 3'd3,
    CFG_GROUP_B    = 3'd4,
    CFG_GROUP_C    = 3'd5,
    CFG_GROUP_D    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                kind;
    logic [COLOUR_W-1:0] colour_a;
    logic [COLOUR_W-1:0] colour_b;
    logic [COLOUR_W-1:0] colour_c;
    logic [COLOUR_W-1:0] colour_d;
  } lsps_in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic start_ignored;
  } lsps_out_t;

  // select the colour word of a group from an input beat
  function automatic logic [COLOUR_W-1:0] lsps_pick_colour(input lsps_in_t d,
                                                           input logic [1:0] g);
    logic [COLOUR_W-1:0] c;
    case (g)
      2'd0:    c = d.colour_a;
      2'd1:    c = d.colour_b;
      2'd2:    c = d.colour_c;
      default: c = d.colour_d;
    endcase
    return c;
  endfunction

endpackage

// ===== design/lsps_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_out_buf
// Two-entry result buffer: an output register plus a skid register.
// ----------------------------------------------------------------------------
module lsps_out_buf
  import lsps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lsps_out_t push_data,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output lsps_out_t out_data
);

  logic      main_vld_r, main_vld_nxt;
  logic      skid_vld_r, skid_vld_nxt;
  lsps_out_t main_r, main_nxt;
  lsps_out_t skid_r, skid_nxt;
  logic      pop;

  assign pop       = main_vld_r && out_ready;
  assign can_push  = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (!main_vld_r || pop) begin
      // refill the output register, oldest beat first
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        main_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        main_nxt     = push_data;
        main_vld_nxt = push;
      end
    end else if (push) begin
      // output stalled: park the new beat
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== design/led_strip_pulse_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_pulse_serializer
// One-wire encoder for a chain of LED chips: each beat is a timing tick or a frame start.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                               Direction  Beat
//  -------  ----------------------------------  ---------  --------------------
//  in       in_valid / in_ready / in_data       input      tick or frame start
//  out      out_valid / out_ready / out_data    output     line level and flags
//  cfg      cfg_we / cfg_idx / cfg_wdata        input      register write
//
//  Every accepted beat yields exactly one result beat through the result
//  buffer, and a new beat is taken every cycle while the output keeps up.
//  The serializer state and the result are produced by one pass of logic
//  between the state registers and a two-entry result buffer.
//  When the output stalls, one more beat is parked in the skid register;
//  in_ready drops only once both result entries are full.
//  rst_n is synchronous: it clears the frame state and the buffer and loads
//  the register defaults (60 / 127 / 186 ticks, groups of 6, 5, 5, 5 chips).
//
module led_strip_pulse_serializer
  import lsps_pkg::*;
#(
  parameter int BITS_PER_CHIP = LSPS_BITS_PER_CHIP,
  parameter int GROUPS        = LSPS_GROUPS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lsps_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lsps_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BIT_IDX_W = $clog2(BITS_PER_CHIP);
  localparam int GIDX_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  typedef struct packed {
    logic              found;
    logic [GIDX_W-1:0] idx;
  } grp_sel_t;

  // configuration registers
  logic [TICK_W-1:0]   zero_hi_r;
  logic [TICK_W-1:0]   one_hi_r;
  logic [TICK_W-1:0]   period_r;
  logic [CHIP_W-1:0]   cnt_r [4];

  // frame state
  logic [COLOUR_W-1:0]      colour_r [GROUPS];
  logic [BITS_PER_CHIP-1:0] shift_r, shift_nxt;
  logic [BIT_IDX_W-1:0]     bit_idx_r, bit_idx_nxt;
  logic [TICK_W-1:0]        phase_r, phase_nxt;
  logic [CHIP_W-1:0]        chip_r, chip_nxt;
  logic [GIDX_W-1:0]        grp_r, grp_nxt;
  logic                     sending_r, sending_nxt;

  logic                     accept;
  logic                     is_start;
  logic                     load_store;
  logic [TICK_W-1:0]        high_ticks;
  logic [TICK_W-1:0]        period_eff;
  logic [TICK_W-1:0]        phase_inc;
  logic                     bit_end;
  logic                     last_bit;
  logic [CHIP_W-1:0]        chip_inc;
  logic                     grp_end;
  grp_sel_t                 first_grp;
  grp_sel_t                 nxt_grp;
  logic [GIDX_W-1:0]        rd_idx;
  logic [BITS_PER_CHIP-1:0] rd_word;
  logic                     buf_can_push;
  lsps_out_t                res;

  // fit a colour word to the chip word: zero-extend or keep the low bits
  function automatic logic [BITS_PER_CHIP-1:0] word_of(input logic [COLOUR_W-1:0] c);
    logic [COLOUR_W+BITS_PER_CHIP-1:0] ext;
    ext = {{BITS_PER_CHIP{1'b0}}, c};
    return ext[BITS_PER_CHIP-1:0];
  endfunction

  // first group at or after 'from' with a nonzero chip count
  function automatic grp_sel_t next_group(input logic [GIDX_W:0] from);
    grp_sel_t sel;
    sel = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if ((GIDX_W+1)'(g) >= from && cnt_r[g] != '0) begin
        sel.found = 1'b1;
        sel.idx   = GIDX_W'(g);
      end
    end
    return sel;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = buf_can_push;
  assign is_start = (in_data.kind == KIND_START);

  // pulse timing of the current bit
  assign high_ticks = shift_r[BITS_PER_CHIP-1] ? one_hi_r : zero_hi_r;
  assign period_eff = (period_r == '0) ? TICK_W'(1) : period_r;
  assign phase_inc  = phase_r + TICK_W'(1);
  assign bit_end    = (phase_inc >= period_eff);
  assign last_bit   = (bit_idx_r == BIT_IDX_W'(BITS_PER_CHIP - 1));

  // chip and group progress
  assign chip_inc  = chip_r + CHIP_W'(1);
  assign grp_end   = (chip_inc >= cnt_r[2'(grp_r)]);
  assign first_grp = next_group('0);
  assign nxt_grp   = next_group({1'b0, grp_r} + (GIDX_W+1)'(1));

  // one store read: the next group's word at a group change, else a repeat
  assign rd_idx  = grp_end ? nxt_grp.idx : grp_r;
  assign rd_word = word_of(colour_r[rd_idx]);

  always_comb begin
    shift_nxt   = shift_r;
    bit_idx_nxt = bit_idx_r;
    phase_nxt   = phase_r;
    chip_nxt    = chip_r;
    grp_nxt     = grp_r;
    sending_nxt = sending_r;
    load_store  = 1'b0;
    res         = '0;
    if (accept) begin
      if (is_start && !sending_r) begin
        // take the colours; a frame with no chips ends at once
        load_store = 1'b1;
        if (!first_grp.found) begin
          res.frame_done = 1'b1;
        end else begin
          grp_nxt      = first_grp.idx;
          shift_nxt    = word_of(lsps_pick_colour(in_data, 2'(first_grp.idx)));
          bit_idx_nxt  = '0;
          phase_nxt    = '0;
          chip_nxt     = '0;
          sending_nxt  = 1'b1;
          res.busy_res = 1'b1;
        end
      end else begin
        // a start while busy counts as a plain tick
        res.start_ignored = is_start;
        res.busy_res      = sending_r;
        if (sending_r) begin
          res.line_level = (phase_r < high_ticks);
          phase_nxt      = phase_inc;
          if (bit_end) begin
            phase_nxt = '0;
            shift_nxt = shift_r << 1;
            if (last_bit) begin
              bit_idx_nxt = '0;
              chip_nxt    = chip_inc;
              if (grp_end) begin
                if (!nxt_grp.found) begin
                  sending_nxt    = 1'b0;
                  res.frame_done = 1'b1;
                end else begin
                  grp_nxt   = nxt_grp.idx;
                  shift_nxt = rd_word;
                  chip_nxt  = '0;
                end
              end else begin
                shift_nxt = rd_word;
              end
            end else begin
              bit_idx_nxt = bit_idx_r + BIT_IDX_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_hi_r <= RST_ZERO_HIGH;
      one_hi_r  <= RST_ONE_HIGH;
      period_r  <= RST_BIT_PERIOD;
      cnt_r[0]  <= RST_GROUP_A;
      cnt_r[1]  <= RST_GROUP_BCD;
      cnt_r[2]  <= RST_GROUP_BCD;
      cnt_r[3]  <= RST_GROUP_BCD;
      shift_r   <= '0;
      bit_idx_r <= '0;
      phase_r   <= '0;
      chip_r    <= '0;
      grp_r     <= '0;
      sending_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          CFG_ZERO_HIGH:  zero_hi_r <= cfg_wdata;
          CFG_ONE_HIGH:   one_hi_r  <= cfg_wdata;
          CFG_BIT_PERIOD: period_r  <= cfg_wdata;
          CFG_GROUP_A:    cnt_r[0]  <= cfg_wdata[CHIP_W-1:0];
          CFG_GROUP_B:    cnt_r[1]  <= cfg_wdata[CHIP_W-1:0];
          CFG_GROUP_C:    cnt_r[2]  <= cfg_wdata[CHIP_W-1:0];
          CFG_GROUP_D:    cnt_r[3]  <= cfg_wdata[CHIP_W-1:0];
          default: ;
        endcase
      end
      shift_r   <= shift_nxt;
      bit_idx_r <= bit_idx_nxt;
      phase_r   <= phase_nxt;
      chip_r    <= chip_nxt;
      grp_r     <= grp_nxt;
      sending_r <= sending_nxt;
    end
  end

  // colour store: written only by a start accepted while idle, read only afterwards
  always_ff @(posedge clk) begin
    if (load_store) begin
      for (int g = 0; g < GROUPS; g++) begin
        colour_r[g] <= lsps_pick_colour(in_data, 2'(g));
      end
    end
  end

  lsps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .can_push  (buf_can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/lsps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsps_checker
// Port-level checks of the LED strip pulse serializer, bound to the top level.
// ----------------------------------------------------------------------------
module lsps_checker
  import lsps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input lsps_out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // every accepted beat leaves a valid result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

  // input stalls only while results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result buffer");

  // the line is driven high and starts are refused only inside a frame
  a_busy_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.line_level || out_data.start_ignored) |-> out_data.busy_res)
    else $error("line high or start refused outside a frame");

endmodule

bind led_strip_pulse_serializer lsps_checker u_lsps_checker (.*);
